### design/sve_pkg.sv
// sve_pkg: request types, register indexes and pipeline layout constants
// for the shadow vertex extruder. Depends on nothing.
package sve_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic               last_vertex;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               was_extruded;
        logic               clipped;
        logic               last_out;
    } out_t;

    // fields carried alongside the arithmetic through every stage
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][30:0] an;    // normalised magnitudes of D
        logic [2:0]       dneg;
        logic             ext;
        logic             last;
    } carry_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 2'd3;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    localparam int ST_SQ0    = 7;
    localparam int ST_DV0    = ST_SQ0 + SQ_STEPS;
    localparam int ST_MUL    = ST_DV0 + DIV_STEPS;
    localparam int ST_OFS    = ST_MUL + 1;
    localparam int ST_OUT    = ST_OFS + 1;
    localparam int NST       = ST_OUT + 1;

endpackage

### design/shadow_vertex_extruder.sv
// shadow_vertex_extruder: 73-stage pipeline, one request accepted per cycle
// unless m_ready stalls it; most of the depth comes from the 32-step square
// root and the 31-step dividers.
// Stages advance on their own, so bubbles close up while m_ready is low.
// Reset (aresetn low, synchronous) empties the pipeline and clears the
// light position and extrude distance to zero. Depends on sve_pkg.
module shadow_vertex_extruder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sve_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sve_pkg::out_t                      m_data,
    input  logic                               cfg_wr_en,
    input  logic [sve_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_wdata
);

    localparam int NST = sve_pkg::NST;
    localparam int SQN = sve_pkg::SQ_STEPS;
    localparam int DVN = sve_pkg::DIV_STEPS;
    localparam int SQ0 = sve_pkg::ST_SQ0;
    localparam int DV0 = sve_pkg::ST_DV0;
    localparam int SMU = sve_pkg::ST_MUL;
    localparam int SOF = sve_pkg::ST_OFS;
    localparam int SOU = sve_pkg::ST_OUT;

    logic signed [31:0] light_reg [3];
    logic [31:0]        dist_reg;

    logic [NST-1:0]     vld_reg;
    logic [NST-1:0]     en;

    sve_pkg::carry_t    cr_reg  [NST];
    sve_pkg::carry_t    cr_next [NST];

    logic signed [32:0] d_reg    [3];
    logic signed [15:0] n_reg    [3];
    logic signed [48:0] prod_reg [3];
    logic [32:0]        a1_reg   [3];
    logic [32:0]        a2_reg   [3];
    logic [32:0]        m_reg;
    logic [32:0]        a3_reg   [3];
    logic [4:0]         shl_reg;
    logic [1:0]         shr_reg;
    logic [61:0]        sq_reg   [3];
    logic [63:0]        sum_reg;

    logic signed [50:0] dot;
    logic [32:0]        m_nx;
    logic [5:0]         tpos;

    logic [63:0]        sqn_reg  [SQN];
    logic [63:0]        sqr_reg  [SQN];
    logic [63:0]        sqn_next [SQN];
    logic [63:0]        sqr_next [SQN];

    logic [31:0]        dvr_reg  [DVN][3];
    logic [30:0]        dvq_reg  [DVN][3];
    logic [31:0]        dvl_reg  [DVN];
    logic [31:0]        dvr_next [DVN][3];
    logic [30:0]        dvq_next [DVN][3];
    logic [31:0]        len_g;

    logic [62:0]        mp_reg   [3];
    logic [32:0]        o_reg    [3];
    sve_pkg::out_t      out_reg;
    sve_pkg::out_t      out_next;

    logic signed [31:0] pin [3];
    logic signed [15:0] nin [3];

    assign pin[0] = s_data.pos_x;
    assign pin[1] = s_data.pos_y;
    assign pin[2] = s_data.pos_z;
    assign nin[0] = s_data.nrm_x;
    assign nin[1] = s_data.nrm_y;
    assign nin[2] = s_data.nrm_z;

    // config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg[0] <= '0;
            light_reg[1] <= '0;
            light_reg[2] <= '0;
            dist_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sve_pkg::REG_LIGHT_X:  light_reg[0] <= cfg_wdata;
                sve_pkg::REG_LIGHT_Y:  light_reg[1] <= cfg_wdata;
                sve_pkg::REG_LIGHT_Z:  light_reg[2] <= cfg_wdata;
                sve_pkg::REG_DISTANCE: dist_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage may load when empty or when the stage after it moves on
    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NST-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // side fields
    always_comb begin
        cr_next[0].pos[0] = s_data.pos_x;
        cr_next[0].pos[1] = s_data.pos_y;
        cr_next[0].pos[2] = s_data.pos_z;
        cr_next[0].an     = '0;
        cr_next[0].dneg   = '0;
        cr_next[0].ext    = 1'b0;
        cr_next[0].last   = s_data.last_vertex;
        for (int k = 1; k < NST; k++) begin
            cr_next[k] = cr_reg[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            cr_next[1].dneg[i] = d_reg[i][32];
        end
        cr_next[2].ext = dot[50];
        for (int i = 0; i < 3; i++) begin
            cr_next[4].an[i] = 31'((64'(a3_reg[i]) << shl_reg) >> shr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                cr_reg[k] <= cr_next[k];
            end
        end
    end

    // front end: D, dot product, magnitudes, normalising shift, squares
    always_comb begin
        dot = 51'(prod_reg[0]) + 51'(prod_reg[1]) + 51'(prod_reg[2]);
        m_nx = a1_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (a1_reg[i] > m_nx) begin
                m_nx = a1_reg[i];
            end
        end
        tpos = '0;
        for (int b = 0; b < 33; b++) begin
            if (m_reg[b]) begin
                tpos = 6'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= 33'(pin[i]) - 33'(light_reg[i]);
                n_reg[i] <= nin[i];
            end
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= 49'(d_reg[i]) * 49'(n_reg[i]);
                a1_reg[i]   <= d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
            end
        end
        if (en[2]) begin
            a2_reg <= a1_reg;
            m_reg  <= m_nx;
        end
        if (en[3]) begin
            a3_reg  <= a2_reg;
            shl_reg <= (tpos < 6'd30) ? 5'(6'd30 - tpos) : 5'd0;
            shr_reg <= (tpos > 6'd30) ? 2'(tpos - 6'd30) : 2'd0;
        end
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 62'(cr_reg[4].an[i]) * 62'(cr_reg[4].an[i]);
            end
        end
        if (en[6]) begin
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        end
    end

    // square root, one result bit per stage
    always_comb begin
        for (int k = 0; k < SQN; k++) begin
            logic [63:0] n_in;
            logic [63:0] r_in;
            logic [63:0] bitv;
            logic [63:0] trial;
            n_in  = (k == 0) ? sum_reg : sqn_reg[(k == 0) ? 0 : k - 1];
            r_in  = (k == 0) ? 64'd0   : sqr_reg[(k == 0) ? 0 : k - 1];
            bitv  = 64'd1 << (62 - 2 * k);
            trial = r_in + bitv;
            if (n_in >= trial) begin
                sqn_next[k] = n_in - trial;
                sqr_next[k] = (r_in >> 1) + bitv;
            end else begin
                sqn_next[k] = n_in;
                sqr_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < SQN; k++) begin
            if (en[SQ0 + k]) begin
                sqn_reg[k] <= sqn_next[k];
                sqr_reg[k] <= sqr_next[k];
            end
        end
    end

    assign len_g = (sqr_reg[SQN-1][31:0] == 32'd0) ? 32'd1 : sqr_reg[SQN-1][31:0];

    // restoring dividers, one quotient bit per stage, three lanes
    always_comb begin
        for (int j = 0; j < DVN; j++) begin
            for (int i = 0; i < 3; i++) begin
                logic [32:0] rem_in;
                logic [31:0] len_in;
                logic [30:0] q_in;
                if (j == 0) begin
                    rem_in = {2'b00, cr_reg[DV0-1].an[i]};
                    len_in = len_g;
                    q_in   = '0;
                end else begin
                    rem_in = {dvr_reg[(j == 0) ? 0 : j - 1][i], 1'b0};
                    len_in = dvl_reg[(j == 0) ? 0 : j - 1];
                    q_in   = dvq_reg[(j == 0) ? 0 : j - 1][i];
                end
                if (rem_in >= {1'b0, len_in}) begin
                    dvr_next[j][i] = 32'(rem_in - {1'b0, len_in});
                    dvq_next[j][i] = {q_in[29:0], 1'b1};
                end else begin
                    dvr_next[j][i] = rem_in[31:0];
                    dvq_next[j][i] = {q_in[29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < DVN; j++) begin
            if (en[DV0 + j]) begin
                dvl_reg[j] <= (j == 0) ? len_g : dvl_reg[(j == 0) ? 0 : j - 1];
                for (int i = 0; i < 3; i++) begin
                    dvr_reg[j][i] <= dvr_next[j][i];
                    dvq_reg[j][i] <= dvq_next[j][i];
                end
            end
        end
    end

    // scale by distance, round, apply with saturation
    always_comb begin
        out_next              = '0;
        out_next.last_out     = cr_reg[SOU-1].last;
        for (int i = 0; i < 3; i++) begin
            logic signed [34:0] pe;
            logic signed [34:0] oe;
            logic signed [34:0] r;
            logic [31:0]        res;
            pe = 35'($signed(cr_reg[SOU-1].pos[i]));
            oe = $signed({2'b00, o_reg[i]});
            r  = cr_reg[SOU-1].dneg[i] ? pe - oe : pe + oe;
            if (!cr_reg[SOU-1].ext) begin
                res = cr_reg[SOU-1].pos[i];
            end else if (r > 35'sd2147483647) begin
                res = 32'h7fff_ffff;
                out_next.clipped = 1'b1;
            end else if (r < -35'sd2147483648) begin
                res = 32'h8000_0000;
                out_next.clipped = 1'b1;
            end else begin
                res = r[31:0];
            end
            unique case (i)
                0:       out_next.out_x = res;
                1:       out_next.out_y = res;
                default: out_next.out_z = res;
            endcase
        end
        out_next.was_extruded = cr_reg[SOU-1].ext;
    end

    always_ff @(posedge aclk) begin
        if (en[SMU]) begin
            for (int i = 0; i < 3; i++) begin
                mp_reg[i] <= 63'(dvq_reg[DVN-1][i]) * 63'(dist_reg);
            end
        end
        if (en[SOF]) begin
            for (int i = 0; i < 3; i++) begin
                o_reg[i] <= 33'((mp_reg[i] + (63'd1 << 29)) >> 30);
            end
        end
        if (en[SOU]) begin
            out_reg <= out_next;
        end
    end

endmodule

### design/sve_chk.sv
// sve_chk: port-level checks on shadow_vertex_extruder, bound to the top.
// Depends on sve_pkg.
module sve_chk (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input sve_pkg::out_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.was_extruded |-> !m_data.clipped)
        else $error("clipped without extrusion");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind shadow_vertex_extruder sve_chk u_sve_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/testbench.sv
// testbench: streams vertex requests through shadow_vertex_extruder and
// checks every result against an in-bench extrusion predictor.
// Depends on sve_pkg and the design top level.
module testbench;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    sve_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    sve_pkg::out_t m_data;
    logic          cfg_wr_en = 1'b0;
    logic [sve_pkg::CFG_IDX_W-1:0] cfg_index = sve_pkg::REG_LIGHT_X;
    logic [31:0]   cfg_wdata = '0;

    shadow_vertex_extruder dut (.*);

    always #5 aclk = ~aclk;

    // predictor copy of the registers
    logic signed [31:0] lgt_x = 0, lgt_y = 0, lgt_z = 0;
    logic [31:0]        ext_dist = 0;

    sve_pkg::in_t  pending_vertices[$];
    sve_pkg::out_t expected_positions[$];
    int   mismatches = 0;
    int   s_wait = 0, m_wait = 0;
    bit   stim_done = 0;
    bit   s_taken = 0, m_taken = 0;
    bit   s_nv;

    function automatic void add_vertex(sve_pkg::in_t v);
        pending_vertices = {pending_vertices, v};
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt >>= 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic sve_pkg::out_t extrude(sve_pkg::in_t v);
        sve_pkg::out_t r;
        logic signed [63:0] p[3], d[3], lt[3], nn[3], dot, o, s;
        logic [63:0] a[3], m, sum, len, u;
        bit clip;
        p[0] = 64'(v.pos_x); p[1] = 64'(v.pos_y); p[2] = 64'(v.pos_z);
        nn[0] = 64'(v.nrm_x); nn[1] = 64'(v.nrm_y); nn[2] = 64'(v.nrm_z);
        lt[0] = 64'(lgt_x); lt[1] = 64'(lgt_y); lt[2] = 64'(lgt_z);
        dot = 0;
        clip = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = p[i] - lt[i];
            dot += d[i] * nn[i];
        end
        r = '0;
        r.last_out = v.last_vertex;
        if (dot < 0) begin
            m = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = d[i] < 0 ? -d[i] : d[i];
                if (a[i] > m) m = a[i];
            end
            while (m < (64'd1 << 30)) begin
                m <<= 1;
                for (int i = 0; i < 3; i++) a[i] <<= 1;
            end
            while (m >= (64'd1 << 31)) begin
                m >>= 1;
                for (int i = 0; i < 3; i++) a[i] >>= 1;
            end
            sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
            len = isqrt(sum);
            if (len == 0) len = 1;
            for (int i = 0; i < 3; i++) begin
                u = (a[i] << 30) / len;
                o = (u * 64'(ext_dist) + (64'd1 << 29)) >> 30;
                s = d[i] < 0 ? p[i] - o : p[i] + o;
                if (s > 64'sd2147483647) begin
                    s = 64'sd2147483647; clip = 1;
                end else if (s < -64'sd2147483648) begin
                    s = -64'sd2147483648; clip = 1;
                end
                p[i] = s;
            end
            r.was_extruded = 1'b1;
            r.clipped = clip;
        end
        r.out_x = p[0][31:0]; r.out_y = p[1][31:0]; r.out_z = p[2][31:0];
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            s_nv = s_valid && !s_taken;
            if (s_taken) s_wait = $urandom_range(0, 6);
            if (!s_nv) begin
                if (s_wait > 0) begin
                    s_wait--;
                end else if (pending_vertices.size() > 0) begin
                    s_data <= pending_vertices.pop_front();
                    s_nv = 1'b1;
                end
            end
            s_valid <= s_nv;
            if (m_taken) m_wait = $urandom_range(0, 6);
            if (m_wait > 0) begin
                m_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        s_taken = aresetn && s_valid && s_ready;
        m_taken = aresetn && m_valid && m_ready;
        if (s_taken)
            expected_positions = {expected_positions, extrude(s_data)};
        if (m_taken) begin
            if (expected_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                sve_pkg::out_t e;
                e = expected_positions.pop_front();
                if (e !== m_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, m_data);
                end
            end
        end
    end

    task automatic write_reg(logic [sve_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            sve_pkg::REG_LIGHT_X:  lgt_x = val;
            sve_pkg::REG_LIGHT_Y:  lgt_y = val;
            sve_pkg::REG_LIGHT_Z:  lgt_z = val;
            sve_pkg::REG_DISTANCE: ext_dist = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_vertices.size() > 0 || s_valid || expected_positions.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh00ffffff;
        endcase
    endfunction

    function automatic sve_pkg::in_t rand_vertex(int mode);
        sve_pkg::in_t v;
        v.pos_x = rand_coord(mode); v.pos_y = rand_coord(mode); v.pos_z = rand_coord(mode);
        v.nrm_x = 16'($urandom); v.nrm_y = 16'($urandom); v.nrm_z = 16'($urandom);
        if ($urandom_range(0, 9) == 0) v.nrm_y = 0;
        v.last_vertex = $urandom_range(0, 15) == 0;
        return v;
    endfunction

    initial begin
        sve_pkg::in_t v;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: reset registers, light on vertex, zero normal, extremes
        v = '0; v.nrm_x = 16'sh4000; add_vertex(v);
        v = '0; v.pos_x = 32'h7fffffff; v.nrm_x = 16'sh8000; add_vertex(v);
        drain();
        write_reg(sve_pkg::REG_DISTANCE, 32'hffffffff);
        write_reg(sve_pkg::REG_LIGHT_X, 32'h00010000);
        write_reg(sve_pkg::REG_LIGHT_Y, 32'h80000000);
        write_reg(sve_pkg::REG_LIGHT_Z, 32'h7fffffff);
        v = '0; v.pos_x = 32'h00010000; v.pos_y = 32'h80000000;
        v.pos_z = 32'h7fffffff; v.nrm_z = 16'sh8000; v.last_vertex = 1;
        add_vertex(v);
        v = '0; v.pos_x = 32'h80000000; v.pos_y = 32'h7fffffff;
        v.pos_z = 32'h80000000; v.nrm_x = 16'sh7fff; v.nrm_y = 16'sh8000;
        v.nrm_z = 16'sh7fff; add_vertex(v);
        v.nrm_x = 0; v.nrm_y = 0; v.nrm_z = 0; add_vertex(v);
        v.pos_x = 32'h00010001; v.nrm_x = 16'sh8000; add_vertex(v);
        for (int k = 0; k < 12; k++) add_vertex(rand_vertex(k % 3));
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(sve_pkg::REG_LIGHT_X, ph == 5 ? 32'h7fffffff : rand_coord(ph % 3));
            write_reg(sve_pkg::REG_LIGHT_Y, rand_coord(ph % 3));
            write_reg(sve_pkg::REG_LIGHT_Z, ph == 5 ? 32'h80000000 : rand_coord(ph % 3));
            case (ph)
                0: write_reg(sve_pkg::REG_DISTANCE, 32'd0);
                1: write_reg(sve_pkg::REG_DISTANCE, 32'hffffffff);
                default: write_reg(sve_pkg::REG_DISTANCE, $urandom_range(0, 32'h00ffffff));
            endcase
            for (int k = 0; k < 225; k++)
                add_vertex(rand_vertex($urandom_range(0, 5) == 0 ?
                                       $urandom_range(0, 1) : 2));
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
